[rtl/bale_pkg.sv]
// bale_pkg: command and status codes, controller/datapath command struct.
// No dependencies.
`timescale 1ns / 1ps
package bale_pkg;

  localparam int CmdW = 4;
  localparam int StW  = 3;

  localparam logic [CmdW-1:0] CMD_INS_FRONT  = 4'd0;
  localparam logic [CmdW-1:0] CMD_INS_BACK   = 4'd1;
  localparam logic [CmdW-1:0] CMD_INS_SORTED = 4'd2;
  localparam logic [CmdW-1:0] CMD_REM_FRONT  = 4'd3;
  localparam logic [CmdW-1:0] CMD_REM_BACK   = 4'd4;
  localparam logic [CmdW-1:0] CMD_REM_VALUE  = 4'd5;
  localparam logic [CmdW-1:0] CMD_REVERSE    = 4'd6;
  localparam logic [CmdW-1:0] CMD_SORT       = 4'd7;
  localparam logic [CmdW-1:0] CMD_CLEAR      = 4'd8;

  localparam logic [StW-1:0] ST_OK       = 3'd0;
  localparam logic [StW-1:0] ST_FULL     = 3'd1;
  localparam logic [StW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StW-1:0] ST_DUP      = 3'd3;
  localparam logic [StW-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic load;     // latch command and value
    logic exec;     // run the latched list operation
    logic sort_odd; // one odd-even transposition pass, odd pairs
    logic sort_even;
  } ctl_t;

  typedef struct packed {
    logic sorted;   // list is non-decreasing
    logic is_sort;  // latched command is sort
  } sts_t;

endpackage

[rtl/bounded_array_list_engine_unit.sv]
// bounded_array_list_engine_unit: top level joining controller and datapath.
// Depends on bale_pkg, bale_ctrl, bale_dp.
//
//  channel | ports                                   | handshake
//  input   | in_cmd, in_value                        | start & !busy
//  result  | out_status, out_removed_value, out_count,| out_valid, one cycle
//          | out_is_empty, out_is_sorted             |
//
// A non-sort command runs through EXEC and DONE after the accept; sort runs
// its odd-even transposition passes in SORT, one pass per cycle, before DONE.
// busy is high from the accept edge until the result cycle ends.
// Reset is synchronous, active low; it empties the list.
// The receiver cannot stall: out_valid lasts exactly one cycle.
`timescale 1ns / 1ps
module bounded_array_list_engine_unit
  import bale_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_cmd,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_removed_value,
  output logic [4:0]         out_count,
  output logic               out_is_empty,
  output logic               out_is_sorted
);
  ctl_t ctl;
  sts_t sts;

  bale_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .ctl(ctl), .sts(sts), .done(out_valid)
  );

  bale_dp #(.CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .cmd(in_cmd), .value(in_value),
    .status(out_status), .removed_value(out_removed_value), .count(out_count)
  );

  assign out_is_empty  = (out_count == 5'd0);
  assign out_is_sorted = sts.sorted;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word not taken");
  a_sorted_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> out_is_sorted) else $error("empty list unsorted");
endmodule

[rtl/bale_ctrl.sv]
// bale_ctrl: controller state machine; sequences list ops and sort passes.
// Depends on bale_pkg.
`timescale 1ns / 1ps
module bale_ctrl
  import bale_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output ctl_t ctl,
  input  sts_t sts,
  output logic done
);
  localparam int PW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SORT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] pass_r, pass_nxt;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    ctl       = '0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_sort) begin
          pass_nxt  = '0;
          state_nxt = S_SORT;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SORT: begin
        ctl.sort_odd  = pass_r[0];
        ctl.sort_even = ~pass_r[0];
        pass_nxt      = pass_r + 1'b1;
        if (pass_r == PW'(CAPACITY - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end
endmodule

[rtl/bale_dp.sv]
// bale_dp: register chain of list cells, fill count and result registers.
// Depends on bale_pkg.
`timescale 1ns / 1ps
module bale_dp
  import bale_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic [CmdW-1:0]       cmd,
  input  logic signed [15:0]    value,
  output logic [StW-1:0]        status,
  output logic signed [15:0]    removed_value,
  output logic [4:0]            count
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [ELEM_WIDTH-1:0] cells_r [CAPACITY];
  logic signed [ELEM_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [CmdW-1:0] cmd_r;
  logic signed [ELEM_WIDTH-1:0] val_r;
  logic [StW-1:0] st_r, st_nxt;
  logic signed [15:0] rem_r, rem_nxt;

  logic [CAPACITY-1:0] valid, eq, lt, gt_next;
  logic full, empty, found, is_dup;
  logic [CW-1:0] pos_lt, pos_eq;
  logic signed [ELEM_WIDTH-1:0] sv;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]   = (CW'(i) < fill_r);
      eq[i]      = valid[i] && (cells_r[i] == val_r);
      lt[i]      = valid[i] && (cells_r[i] < val_r);
      gt_next[i] = (i + 1 < CAPACITY) && (CW'(i + 1) < fill_r) &&
                   (cells_r[i] > cells_r[(i + 1) % CAPACITY]);
    end
  end

  // first-match and insertion position
  always_comb begin
    pos_eq = CW'(CAPACITY);
    pos_lt = fill_r;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq[i]) pos_eq = CW'(i);
      if (valid[i] && !lt[i]) pos_lt = CW'(i);
    end
  end

  assign full   = (fill_r == CW'(CAPACITY));
  assign empty  = (fill_r == '0);
  assign found  = |eq;
  assign is_dup = found;
  assign sv     = ELEM_WIDTH'(value);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) cells_nxt[i] = cells_r[i];
    fill_nxt = fill_r;
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    if (ctl.load) begin
      st_nxt  = ST_OK;
      rem_nxt = '0;
    end
    if (ctl.exec) begin
      unique case (cmd_r)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SORTED: begin
          if (full) st_nxt = ST_FULL;
          else if (cmd_r == CMD_INS_SORTED && is_dup) st_nxt = ST_DUP;
          else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (cmd_r == CMD_INS_FRONT) begin
                if (i == 0) cells_nxt[i] = val_r;
                else cells_nxt[i] = cells_r[i - 1];
              end else if (cmd_r == CMD_INS_BACK) begin
                if (CW'(i) == fill_r) cells_nxt[i] = val_r;
              end else begin
                if (CW'(i) == pos_lt) cells_nxt[i] = val_r;
                else if (CW'(i) > pos_lt && i > 0) cells_nxt[i] = cells_r[i - 1];
              end
            end
            fill_nxt = fill_r + 1'b1;
          end
        end
        CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_VALUE: begin
          if (empty) st_nxt = ST_EMPTY;
          else if (cmd_r == CMD_REM_VALUE && !found) st_nxt = ST_NOTFOUND;
          else begin
            if (cmd_r == CMD_REM_FRONT) rem_nxt = 16'(cells_r[0]);
            else if (cmd_r == CMD_REM_BACK)
              rem_nxt = 16'(cells_r[IW'(fill_r - 1'b1)]);
            else rem_nxt = 16'(val_r);
            for (int i = 0; i + 1 < CAPACITY; i++) begin
              if (cmd_r == CMD_REM_FRONT) cells_nxt[i] = cells_r[i + 1];
              else if (cmd_r == CMD_REM_VALUE && CW'(i) >= pos_eq)
                cells_nxt[i] = cells_r[i + 1];
            end
            fill_nxt = fill_r - 1'b1;
          end
        end
        CMD_REVERSE: begin
          for (int i = 0; i < CAPACITY; i++)
            if (valid[i]) cells_nxt[i] = cells_r[IW'(fill_r - 1'b1 - CW'(i))];
        end
        CMD_CLEAR: fill_nxt = '0;
        default: ;
      endcase
    end
    if (ctl.sort_even || ctl.sort_odd) begin
      for (int i = 0; i + 1 < CAPACITY; i++) begin
        if (((i % 2 == 0) == ctl.sort_even) && gt_next[i]) begin
          cells_nxt[i]     = cells_r[i + 1];
          cells_nxt[i + 1] = cells_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) cells_r[i] <= cells_nxt[i];
    st_r  <= st_nxt;
    rem_r <= rem_nxt;
    if (ctl.load) begin
      cmd_r <= cmd;
      val_r <= sv;
    end
  end

  assign sts.sorted  = ~|gt_next;
  assign sts.is_sort = (cmd_r == CMD_SORT);
  assign status        = st_r;
  assign removed_value = rem_r;
  assign count         = 5'(fill_r);
endmodule
